[hw/rtl/joystick_radial_deadzone_defines.svh]
// Assertion macros shared by the joystick radial deadzone RTL.
`ifndef JOYSTICK_RADIAL_DEADZONE_DEFINES_SVH
`define JOYSTICK_RADIAL_DEADZONE_DEFINES_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge out of reset.
`define JRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define JRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define JRD_ASSERT(lbl, prop, msg)
`define JRD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/jrd_pkg.sv]
// Types and constants shared by the joystick radial deadzone modules.
`timescale 1ns / 1ps

package jrd_pkg;

  // Event types and codes
  localparam logic [15:0] EVT_ABS     = 16'd3;
  localparam logic [15:0] EVT_KEY     = 16'd1;
  localparam logic [15:0] AXIS_CODE_X = 16'd0;
  localparam logic [15:0] AXIS_CODE_Y = 16'd1;
  localparam logic [15:0] KEY_A       = 16'h0130;
  localparam logic [15:0] KEY_START   = 16'h013b;
  localparam logic [15:0] KEY_BACK    = 16'h013a;

  // Button bit masks: bit 0 A, bit 1 start, bit 2 back
  localparam logic [2:0] MASK_NONE  = 3'b000;
  localparam logic [2:0] MASK_A     = 3'b001;
  localparam logic [2:0] MASK_START = 3'b010;
  localparam logic [2:0] MASK_BACK  = 3'b100;

  localparam logic [14:0] FULL_SCALE = 15'h7fff;
  localparam logic [14:0] DZ_RESET   = 15'd8000;

  // Datapath widths
  localparam int unsigned ROOT_W = 16;  // floor(sqrt(2^31)) fits 16 bits
  localparam int unsigned PROD_W = 32;  // component * (mag - dz)
  localparam int unsigned DEN_W  = 31;  // mag * (32767 - dz)
  localparam int unsigned QUO_W  = 17;  // quotient bits kept below saturation

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ABS,
    KIND_KEY
  } kind_e;

  typedef enum logic [1:0] {
    AXIS_NONE,
    AXIS_X,
    AXIS_Y
  } axis_e;

  typedef struct packed {
    kind_e       kind;
    axis_e       axis;
    logic [2:0]  key_mask;
    logic [15:0] value;
  } item_t;

  // Head of the event queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_MULD,
    ST_MULX,
    ST_MULY,
    ST_DIVGO,
    ST_DIV,
    ST_EMIT
  } back_state_e;

endpackage

[hw/rtl/jrd_front.sv]
// Front end: accepts raw events, decodes them and queues them for the back end.
`timescale 1ns / 1ps
`include "joystick_radial_deadzone_defines.svh"

module jrd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [31:0]     s_axis_tdata,   // [15:0] event_code, [31:16] event_value
  input  logic [15:0]     s_axis_tuser,   // [15:0] req_type
  input  logic            pop_i,
  output jrd_pkg::q_out_t q_o
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  jrd_pkg::item_t item;
  jrd_pkg::item_t fifo_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push;
  logic [15:0]      code;

  assign code = s_axis_tdata[15:0];

  always_comb begin
    item.value = s_axis_tdata[31:16];
    unique case (s_axis_tuser)
      jrd_pkg::EVT_ABS: item.kind = jrd_pkg::KIND_ABS;
      jrd_pkg::EVT_KEY: item.kind = jrd_pkg::KIND_KEY;
      default:          item.kind = jrd_pkg::KIND_NONE;
    endcase
    unique case (code)
      jrd_pkg::AXIS_CODE_X: item.axis = jrd_pkg::AXIS_X;
      jrd_pkg::AXIS_CODE_Y: item.axis = jrd_pkg::AXIS_Y;
      default:              item.axis = jrd_pkg::AXIS_NONE;
    endcase
    unique case (code)
      jrd_pkg::KEY_A:     item.key_mask = jrd_pkg::MASK_A;
      jrd_pkg::KEY_START: item.key_mask = jrd_pkg::MASK_START;
      jrd_pkg::KEY_BACK:  item.key_mask = jrd_pkg::MASK_BACK;
      default:            item.key_mask = jrd_pkg::MASK_NONE;
    endcase
  end

  assign s_axis_tready = (cnt_q != CNT_W'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;

  assign q_o.valid = (cnt_q != '0);
  assign q_o.item  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (!push && pop_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

  `JRD_ASSERT(a_pop_nonempty, !pop_i || (cnt_q != '0), "queue popped while empty")

endmodule

[hw/rtl/jrd_isqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module jrd_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [31:0]                 n_i,
  output logic                        done_o,
  output logic [jrd_pkg::ROOT_W-1:0]  root_o
);

  localparam int unsigned STEPS = 16;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [31:0]      rem_q, root_q, bit_q;
  logic [31:0]      trial;
  logic             ge;

  assign trial = root_q + bit_q;
  assign ge    = (rem_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= n_i;
      root_q <= '0;
      bit_q  <= 32'h4000_0000;
    end else if (busy_q) begin
      if (ge) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[jrd_pkg::ROOT_W-1:0];

endmodule

[hw/rtl/jrd_div.sv]
// Restoring divider for the stick scale, one quotient bit per cycle with overflow flag.
`timescale 1ns / 1ps

module jrd_div #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [jrd_pkg::PROD_W-1:0] prod_i,  // numerator before the fraction shift
  input  logic [jrd_pkg::DEN_W-1:0]  den_i,
  output logic                       done_o,
  output logic                       ovf_o,   // quotient needs more than QUO_W bits
  output logic [jrd_pkg::QUO_W-1:0]  quo_o
);

  localparam int unsigned QW    = jrd_pkg::QUO_W;
  localparam int unsigned DW    = jrd_pkg::DEN_W;
  localparam int unsigned NW    = jrd_pkg::PROD_W + FRAC_BITS;
  localparam int unsigned HI_W  = NW - QW;
  localparam int unsigned CW    = (HI_W > DW) ? HI_W : DW;
  localparam int unsigned CNT_W = $clog2(QW);

  logic [NW-1:0]    num;
  logic [HI_W-1:0]  hi;
  logic             hi_ge;
  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    den_q, rem_q;
  logic [QW-1:0]    lo_q, quo_q;
  logic             ovf_q;
  logic [DW:0]      r2, r2_sub;
  logic             r2_ge;

  assign num   = {prod_i, {FRAC_BITS{1'b0}}};
  assign hi    = num[NW-1:QW];
  // quotient fits QW bits exactly when the top part is below the divisor
  assign hi_ge = (CW'(hi) >= CW'(den_i));

  assign r2     = {rem_q, lo_q[QW-1]};
  assign r2_sub = r2 - {1'b0, den_q};
  assign r2_ge  = (r2 >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      ovf_q <= hi_ge;
      rem_q <= DW'(hi);
      lo_q  <= num[QW-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= r2_ge ? r2_sub[DW-1:0] : r2[DW-1:0];
      quo_q <= {quo_q[QW-2:0], r2_ge};
      lo_q  <= {lo_q[QW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quo_o  = quo_q;

endmodule

[hw/rtl/jrd_back.sv]
// Back end: applies queued events, runs the stick maths and holds the result register.
`timescale 1ns / 1ps
`include "joystick_radial_deadzone_defines.svh"

module jrd_back #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jrd_pkg::q_out_t q_i,
  output logic            pop_o,
  input  logic [14:0]     dz_i,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // [15:0] stick_x_out, [31:16] stick_y_out, [32] a_pressed, [33] start_pressed,
  // [34] back_pressed, [39:35] zero
  output logic [39:0]     m_axis_tdata
);

  localparam int unsigned RW = jrd_pkg::ROOT_W;
  localparam int unsigned PW = jrd_pkg::PROD_W;
  localparam int unsigned DW = jrd_pkg::DEN_W;
  localparam int unsigned QW = jrd_pkg::QUO_W;

  jrd_pkg::back_state_e state_q, state_d;

  logic [15:0] raw_x_q, raw_y_q, held_x_q, held_y_q;
  logic [2:0]  btn_q, btn_next;
  logic [15:0] ax, ay, ax_q, ay_q;
  logic        negx_q, negy_q;
  logic [31:0] sq_q, sqrt_n;
  logic [RW-1:0] mag_q, root;
  logic [15:0] diff_q;
  logic [DW-1:0] den_q;
  logic [PW-1:0] px_q, py_q;
  logic [14:0] span;
  logic        in_dz;
  logic        sqrt_done, done_x, done_y, ovf_x, ovf_y;
  logic [QW-1:0] quo_x, quo_y;
  logic        out_valid_q, out_free, out_load;
  logic [39:0] out_data_q;
  logic        sqrt_start, div_start;
  logic        is_abs;

  function automatic logic [15:0] sat_comp(input logic neg, input logic zero,
                                           input logic ovf, input logic [QW-1:0] quo);
    logic [QW-1:0] q;
    logic [QW-1:0] q_neg;
    begin
      q = ovf ? {QW{1'b1}} : quo;
      if (neg && (q > QW'(32768))) begin
        q = QW'(32768);
      end else if (!neg && (q > QW'(32767))) begin
        q = QW'(32767);
      end
      q_neg = QW'(0) - q;
      if (zero) begin
        sat_comp = 16'd0;
      end else if (neg) begin
        sat_comp = q_neg[15:0];
      end else begin
        sat_comp = q[15:0];
      end
    end
  endfunction

  assign ax     = raw_x_q[15] ? 16'(-raw_x_q) : raw_x_q;
  assign ay     = raw_y_q[15] ? 16'(-raw_y_q) : raw_y_q;
  assign sqrt_n = sq_q + (32'(ay_q) * 32'(ay_q));
  assign span   = jrd_pkg::FULL_SCALE - dz_i;
  assign in_dz  = (mag_q <= RW'(dz_i));
  assign is_abs = (q_i.item.kind == jrd_pkg::KIND_ABS);

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    btn_next = btn_q;
    if (q_i.item.kind == jrd_pkg::KIND_KEY) begin
      if (q_i.item.value != 16'd0) begin
        btn_next = btn_q | q_i.item.key_mask;
      end else begin
        btn_next = btn_q & ~q_i.item.key_mask;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jrd_pkg::ST_IDLE:  if (q_i.valid && is_abs) state_d = jrd_pkg::ST_SQX;
      jrd_pkg::ST_SQX:   state_d = jrd_pkg::ST_SQY;
      jrd_pkg::ST_SQY:   state_d = jrd_pkg::ST_SQRT;
      jrd_pkg::ST_SQRT:  if (sqrt_done) state_d = jrd_pkg::ST_MULD;
      jrd_pkg::ST_MULD:  state_d = in_dz ? jrd_pkg::ST_EMIT : jrd_pkg::ST_MULX;
      jrd_pkg::ST_MULX:  state_d = jrd_pkg::ST_MULY;
      jrd_pkg::ST_MULY:  state_d = jrd_pkg::ST_DIVGO;
      jrd_pkg::ST_DIVGO: state_d = jrd_pkg::ST_DIV;
      jrd_pkg::ST_DIV:   if (done_x && done_y) state_d = jrd_pkg::ST_EMIT;
      jrd_pkg::ST_EMIT:  if (out_free) state_d = jrd_pkg::ST_IDLE;
      default:           state_d = jrd_pkg::ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    pop_o      = 1'b0;
    out_load   = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      jrd_pkg::ST_IDLE: begin
        // key and ignored events finish here; axis events go on to the maths
        pop_o    = q_i.valid && (is_abs || out_free);
        out_load = q_i.valid && !is_abs && out_free;
      end
      jrd_pkg::ST_SQY:   sqrt_start = 1'b1;
      jrd_pkg::ST_DIVGO: div_start  = 1'b1;
      jrd_pkg::ST_EMIT:  out_load   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jrd_pkg::ST_IDLE;
      raw_x_q     <= '0;
      raw_y_q     <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      btn_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o && is_abs) begin
        if (q_i.item.axis == jrd_pkg::AXIS_X) raw_x_q <= q_i.item.value;
        if (q_i.item.axis == jrd_pkg::AXIS_Y) raw_y_q <= q_i.item.value;
      end
      if (pop_o && (q_i.item.kind == jrd_pkg::KIND_KEY)) begin
        btn_q <= btn_next;
      end
      if ((state_q == jrd_pkg::ST_MULD) && in_dz) begin
        held_x_q <= '0;
        held_y_q <= '0;
      end
      if ((state_q == jrd_pkg::ST_DIV) && done_x && done_y) begin
        held_x_q <= sat_comp(negx_q, ax_q == 16'd0, ovf_x, quo_x);
        held_y_q <= sat_comp(negy_q, ay_q == 16'd0, ovf_y, quo_y);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      jrd_pkg::ST_SQX: begin
        ax_q   <= ax;
        ay_q   <= ay;
        negx_q <= raw_x_q[15];
        negy_q <= !raw_y_q[15] && (raw_y_q != 16'd0);  // Y is flipped
        sq_q   <= 32'(ax) * 32'(ax);
      end
      jrd_pkg::ST_SQRT: if (sqrt_done) mag_q <= root;
      jrd_pkg::ST_MULD: begin
        diff_q <= 16'(mag_q - RW'(dz_i));
        den_q  <= DW'(32'(mag_q) * 32'(span));
      end
      jrd_pkg::ST_MULX: px_q <= 32'(ax_q) * 32'(diff_q);
      jrd_pkg::ST_MULY: py_q <= 32'(ay_q) * 32'(diff_q);
      default: ;
    endcase
    if (out_load) begin
      if (state_q == jrd_pkg::ST_IDLE) begin
        out_data_q <= {5'b0, btn_next, held_y_q, held_x_q};
      end else begin
        out_data_q <= {5'b0, btn_q, held_y_q, held_x_q};
      end
    end
  end

  jrd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .n_i     (sqrt_n),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  jrd_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .prod_i  (px_q),
    .den_i   (den_q),
    .done_o  (done_x),
    .ovf_o   (ovf_x),
    .quo_o   (quo_x)
  );

  jrd_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .prod_i  (py_q),
    .den_i   (den_q),
    .done_o  (done_y),
    .ovf_o   (ovf_y),
    .quo_o   (quo_y)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `JRD_ASSERT(a_div_lockstep, done_x == done_y, "dividers out of step")
  `JRD_ASSERT(a_load_free, !out_load || !out_valid_q || m_axis_tready, "result overwritten")
  `JRD_ASSERT_NEXT(a_abs_starts, pop_o && is_abs, state_q == jrd_pkg::ST_SQX, "axis event not started")

endmodule

[hw/rtl/joystick_radial_deadzone.sv]
// Joystick radial deadzone conditioner: top level.
`timescale 1ns / 1ps

// Takes raw input events (type on s_axis_tuser, code and value on s_axis_tdata) and
// returns one result per event: the conditioned stick X/Y in signed fixed point with
// OUT_FRAC_BITS fraction bits, plus the A, start and back button states. Axis events
// store X or Y and rescale the stick outside the radial deadzone; key events update
// the buttons; anything else repeats the held outputs. Key and ignored events are
// handled in the back end's idle state. An axis event runs the 16-step square root
// of x*x+y*y, then the 17-step restoring divide (both components divide in parallel).
// A two-entry queue sits between the front end and the back end, and the result
// register lets the next event be accepted while a result waits. The user must write
// the deadzone register through the cfg channel only while idle; this is unchecked.
module joystick_radial_deadzone #(
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] event_code, [31:16] event_value
  input  logic [15:0] s_axis_tuser,   // [15:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] stick_x_out, [31:16] stick_y_out, [32] a_pressed, [33] start_pressed,
  // [34] back_pressed, [39:35] zero
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i      // deadzone_radius
);

  logic [14:0]     dz_q;
  jrd_pkg::q_out_t q_head;
  logic            pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= jrd_pkg::DZ_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dz_q <= cfg_data_i;
    end
  end

  jrd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop_i         (pop),
    .q_o           (q_head)
  );

  jrd_back #(.FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_i           (q_head),
    .pop_o         (pop),
    .dz_i          (dz_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
